// ===== hw/rtl/pcts_pkg.sv =====
package pcts_pkg;

  // fixed field widths
  localparam int unsigned ChanW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned UsedW = 6;

  // item action codes
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } act_e;

  // controller to datapath commands
  typedef struct packed {
    logic             accept;   // item taken this cycle
    logic             walk;     // process the entry at wb_idx
    logic             rd_en;    // read counter and period at rd_idx
    logic [ChanW-1:0] rd_idx;
    logic [ChanW-1:0] wb_idx;
    logic             out_load; // capture the result
  } cmd_t;

endpackage

// ===== hw/rtl/pcts_if.sv =====
// input item channel
interface pcts_in_if;
  import pcts_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [ChanW-1:0] channel;
  logic [DataW-1:0] phase;
  logic [DataW-1:0] period;
  logic             start_now;

  modport source (
    output valid, action, channel, phase, period, start_now,
    input  ready
  );
  modport sink (
    input  valid, action, channel, phase, period, start_now,
    output ready
  );
endinterface

// result item channel
interface pcts_out_if;
  import pcts_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] fired_mask;
  logic [DataW-1:0] done_flags;
  logic [ChanW-1:0] assigned_channel;
  logic             table_full;

  modport source (
    output valid, fired_mask, done_flags, assigned_channel, table_full,
    input  ready
  );
  modport sink (
    input  valid, fired_mask, done_flags, assigned_channel, table_full,
    output ready
  );
endinterface

// ===== hw/rtl/pcts_ram.sv =====
module pcts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pcts_ctrl.sv =====
module pcts_ctrl #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_is_tick_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pcts_pkg::cmd_t cmd_o
);
  import pcts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  localparam logic [ChanW-1:0] LastIdx = ChanW'(NUM_CHANNELS - 1);

  state_e           state_q;
  logic [ChanW-1:0] idx_q;
  logic             out_valid_q;
  logic             out_free;
  logic             accept;

  // handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // command decode
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.wb_idx = idx_q;
    cmd_o.rd_idx = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_is_tick_i) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = '0;
        end else if (accept) begin
          cmd_o.out_load = 1'b1;
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (idx_q != LastIdx) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = idx_q + ChanW'(1);
        end
      end
      ST_FIN: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // state, walk index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && in_is_tick_i) begin
            state_q <= ST_WALK;
            idx_q   <= '0;
          end
        end
        ST_WALK: begin
          if (idx_q == LastIdx) begin
            state_q <= ST_FIN;
          end else begin
            idx_q <= idx_q + ChanW'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // a new result never overwrites one that is still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while stalled");

  // walk stays inside the table
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (idx_q <= LastIdx))
    else $error("walk index out of range");

  // each tick walk moves on to the finish state, which loads the result
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && idx_q == LastIdx) |=> (state_q == ST_FIN))
    else $error("walk did not finish");

endmodule

// ===== hw/rtl/pcts_dpath.sv =====
module pcts_dpath #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcts_pkg::cmd_t              cmd_i,
  input  pcts_pkg::act_e              action_i,
  input  logic [pcts_pkg::ChanW-1:0]  channel_i,
  input  logic [pcts_pkg::DataW-1:0]  phase_i,
  input  logic [pcts_pkg::DataW-1:0]  period_i,
  input  logic                        start_now_i,
  output logic [pcts_pkg::DataW-1:0]  fired_mask_o,
  output logic [pcts_pkg::DataW-1:0]  done_flags_o,
  output logic [pcts_pkg::ChanW-1:0]  assigned_channel_o,
  output logic                        table_full_o
);
  import pcts_pkg::*;

  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [UsedW-1:0]        used_q;
  logic [NUM_CHANNELS-1:0] en_q, en_d;
  logic [NUM_CHANNELS-1:0] done_q, done_d;
  logic [NUM_CHANNELS-1:0] fired_q, fired_d;
  logic [NUM_CHANNELS-1:0] cnt_vld_q, cnt_vld_d;
  logic [NUM_CHANNELS-1:0] per_vld_q, per_vld_d;
  logic [DataW-1:0]        fired_out_q;
  logic [DataW-1:0]        done_out_q;
  logic [ChanW-1:0]        assigned_q;
  logic                    full_out_q;

  logic             full;
  logic             chan_ok;
  logic [AW-1:0]    slot;
  logic [AW-1:0]    cidx;
  logic [AW-1:0]    widx;
  logic             is_add;
  logic             do_add;
  logic             do_start;
  logic             do_stop;
  logic             walk_act;
  logic [DataW-1:0] cnt_rdata, per_rdata;
  logic [DataW-1:0] cur_cnt, cur_per, cnt_inc;
  logic             hit;
  logic             cnt_we;
  logic [AW-1:0]    cnt_waddr;
  logic [DataW-1:0] cnt_wdata;

  // item decode
  assign full     = used_q >= UsedW'(NUM_CHANNELS);
  assign slot     = used_q[AW-1:0];
  assign cidx     = channel_i[AW-1:0];
  assign widx     = cmd_i.wb_idx[AW-1:0];
  assign chan_ok  = {1'b0, channel_i} < UsedW'(NUM_CHANNELS);
  assign is_add   = cmd_i.accept && (action_i == ACT_ADD);
  assign do_add   = is_add && !full;
  assign do_start = cmd_i.accept && (action_i == ACT_START) && chan_ok;
  assign do_stop  = cmd_i.accept && (action_i == ACT_STOP) && chan_ok;

  // per-entry tick update; entries never written read as zero
  assign cur_cnt  = cnt_vld_q[widx] ? cnt_rdata : '0;
  assign cur_per  = per_vld_q[widx] ? per_rdata : '0;
  assign cnt_inc  = cur_cnt + DataW'(1);
  assign hit      = cnt_inc >= cur_per;
  assign walk_act = cmd_i.walk && en_q[widx];

  // counter write port: add loads the phase, walk writes back
  assign cnt_we    = do_add || walk_act;
  assign cnt_waddr = do_add ? slot : widx;
  assign cnt_wdata = do_add ? phase_i : (hit ? '0 : cnt_inc);

  pcts_ram #(
    .WIDTH (DataW),
    .DEPTH (NUM_CHANNELS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_idx[AW-1:0]),
    .rdata_o (cnt_rdata)
  );

  pcts_ram #(
    .WIDTH (DataW),
    .DEPTH (NUM_CHANNELS)
  ) u_per_ram (
    .clk_i   (clk_i),
    .we_i    (do_add),
    .waddr_i (slot),
    .wdata_i (period_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_idx[AW-1:0]),
    .rdata_o (per_rdata)
  );

  // flag vectors next state
  always_comb begin
    en_d      = en_q;
    done_d    = done_q;
    fired_d   = fired_q;
    cnt_vld_d = cnt_vld_q;
    per_vld_d = per_vld_q;
    if (cmd_i.accept) begin
      fired_d = '0;
    end
    if (walk_act) begin
      cnt_vld_d[widx] = 1'b1;
      if (hit) begin
        done_d[widx]  = 1'b1;
        fired_d[widx] = 1'b1;
      end
    end
    if (do_add) begin
      en_d[slot]      = start_now_i;
      done_d[slot]    = 1'b0;
      cnt_vld_d[slot] = 1'b1;
      per_vld_d[slot] = 1'b1;
    end
    if (do_start) begin
      en_d[cidx] = 1'b1;
    end
    if (do_stop) begin
      en_d[cidx]      = 1'b0;
      done_d[cidx]    = 1'b0;
      cnt_vld_d[cidx] = 1'b0;
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      en_q      <= '0;
      done_q    <= '0;
      fired_q   <= '0;
      cnt_vld_q <= '0;
      per_vld_q <= '0;
    end else begin
      en_q      <= en_d;
      done_q    <= done_d;
      fired_q   <= fired_d;
      cnt_vld_q <= cnt_vld_d;
      per_vld_q <= per_vld_d;
      if (do_add) begin
        used_q <= used_q + UsedW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      fired_out_q <= cmd_i.accept ? '0 : DataW'(fired_q);
      done_out_q  <= DataW'(done_d);
      assigned_q  <= do_add ? used_q[ChanW-1:0] : '0;
      full_out_q  <= is_add && full;
    end
  end

  assign fired_mask_o       = fired_out_q;
  assign done_flags_o       = done_out_q;
  assign assigned_channel_o = assigned_q;
  assign table_full_o       = full_out_q;

  // fill count never passes the table size
  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(NUM_CHANNELS))
    else $error("fill count past table size");

  // an add never lands in the middle of a tick walk
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_add && cmd_i.walk))
    else $error("counter write port conflict");

endmodule

// ===== hw/rtl/periodic_channel_tick_scheduler.sv =====
// Periodic channel tick scheduler: a table of NUM_CHANNELS periodic timers.
// in_i carries one item: action (tick, add, start, stop), channel, phase,
// period and start_now. out_o returns exactly one result per item: the fire
// mask of a tick, the sticky done flags after the item, the channel given by
// an add and a table full flag for a refused add.
// Add, start and stop finish in the cycle they are accepted; the result is
// valid on the next cycle. A tick reads every channel's counter and period
// from two single-port-read RAMs, one entry per cycle, and writes each new
// counter back as the walk processes that entry; the tick's result is loaded
// once the walk has ended and out_o is free, and the next item can enter
// only after that load, so the entry walk sets the rate.
// in_i.ready is high only with no tick in progress and the result
// register free or being emptied, so the next item can be taken in the same
// cycle as the waiting result. A stalled out_o holds its result and blocks the
// next tick from finishing and new items from entering.
// Reset clears the fill count, all enable and done flags, and the valid bits
// that make unwritten counters and periods read as zero; no clearing pass.
module periodic_channel_tick_scheduler #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcts_in_if.sink           in_i,
  pcts_out_if.source        out_o
);
  import pcts_pkg::*;

  cmd_t cmd;
  act_e action;

  assign action = act_e'(in_i.action);

  // sequencer
  pcts_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_is_tick_i (action == ACT_TICK),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd)
  );

  // channel table and result register
  pcts_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .action_i           (action),
    .channel_i          (in_i.channel),
    .phase_i            (in_i.phase),
    .period_i           (in_i.period),
    .start_now_i        (in_i.start_now),
    .fired_mask_o       (out_o.fired_mask),
    .done_flags_o       (out_o.done_flags),
    .assigned_channel_o (out_o.assigned_channel),
    .table_full_o       (out_o.table_full)
  );

endmodule
